@@ rtl/dense_matrix_multiply_defines.svh @@
// assertion macros for the dense matrix multiply block
// needs a clock named clk and an active-high reset named rst in the using scope
`ifndef DENSE_MATRIX_MULTIPLY_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_DEFINES_SVH

// condition must never hold outside reset
`define DMM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// consequence in the same cycle
`define DMM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence in the next cycle
`define DMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dmm_pkg.sv @@
// shared types and codes for the dense matrix multiply block
// used by dmm_mac and dense_matrix_multiply; no dependencies
`default_nettype none

package dmm_pkg;

  // operation codes
  localparam logic [1:0] OP_WRITE_A  = 2'd0;
  localparam logic [1:0] OP_WRITE_B  = 2'd1;
  localparam logic [1:0] OP_MULTIPLY = 2'd2;
  localparam logic [1:0] OP_READ_C   = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } rsp_t;

  // one multiply-accumulate step entering the mac pipeline
  typedef struct packed {
    logic valid;
    logic first;  // first term of a cell
    logic last;   // last term of a cell
    logic done;   // last term of the whole multiply
  } mac_ctrl_t;

  // what the mac pipeline reports per cycle
  typedef struct packed {
    logic wr;     // a finished cell is on sum
    logic sat;    // this cycle's addition saturated
    logic done;   // the final cell of the multiply is on sum
  } mac_rsp_t;

endpackage

`default_nettype wire

@@ rtl/dmm_mac.sv @@
// multiply-accumulate pipeline: registered 32x32 product, saturating 64-bit accumulator
// depends on dmm_pkg
`default_nettype none

module dmm_mac
  import dmm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mac_ctrl_t          ctrl,
  input  logic signed [31:0] a_data,
  input  logic signed [31:0] b_data,
  output mac_rsp_t           rsp,
  output logic signed [63:0] sum
);

  mac_ctrl_t          prod_ctrl;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] base;
  logic signed [63:0] raw;
  logic               ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctrl <= '0;
    end else begin
      prod_ctrl <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
  end

  // overflow only when both addends share a sign the sum lacks
  always_comb begin
    base = prod_ctrl.first ? 64'sd0 : acc;
    raw  = base + prod;
    ovf  = (base[63] == prod[63]) && (raw[63] != base[63]);
    sum  = ovf ? (base[63] ? ACC_MIN : ACC_MAX) : raw;
    rsp.wr   = prod_ctrl.valid && prod_ctrl.last;
    rsp.sat  = prod_ctrl.valid && ovf;
    rsp.done = prod_ctrl.valid && prod_ctrl.done;
  end

  always_ff @(posedge clk) begin
    if (prod_ctrl.valid) begin
      acc <= sum;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dense_matrix_multiply.sv @@
// dense square matrix multiply engine, top level
// depends on dmm_pkg, dmm_mac and dense_matrix_multiply_defines.svh
//
// usage:
//   req channel (req_valid/req_ready/req) carries one request per item:
//   write an element of A or B, run the multiply, or read an element of C.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response per
//   request, in order. cfg_we/cfg_wdata set matrix_size while the block idles.
// request handling:
//   element writes and out-of-range requests: response registered from the
//   request, one request per cycle sustained while the skid entry is empty
//   in-range reads of C: the response waits for the registered C memory read,
//   and no new request is taken while the read is in progress
//   multiply: one MAC per cycle through the A/B memory read ports,
//   a registered multiplier and a saturating adder
// reset:
//   control clears at once, no sweep; C reads as zero until the first
//   multiply, tracked by the size of the last multiply instead of a clear
// stall:
//   an output register plus one skid entry hold responses; a new request is
//   taken while a response waits, and ready drops only while the skid is full
//   or a read or multiply is in progress
`default_nettype none

module dense_matrix_multiply
  import dmm_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int AW    = 2 * IDX_W;
  localparam int DEPTH = 1 << AW;
  localparam int SZ_W  = $clog2(MAX_SIZE + 1);
  localparam int CW    = SZ_W + 6;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state;

  // configuration and derived size
  logic [6:0]      cfg_size;
  logic [SZ_W-1:0] n;
  logic [IDX_W-1:0] nm1;
  logic [SZ_W-1:0] last_size;   // size of the last multiply, zero before any
  logic            sat_flag;

  // request decode
  logic          req_fire;
  logic          in_range;
  logic          hit;
  logic [AW-1:0] req_addr;
  logic          read_hit;

  // storage
  logic [31:0] a_mem [DEPTH];
  logic [31:0] b_mem [DEPTH];
  logic [63:0] c_mem [DEPTH];
  logic signed [31:0] a_rd;
  logic signed [31:0] b_rd;
  logic [63:0]        c_rd;

  // multiply sequencer
  logic [IDX_W-1:0] mi, mj, mh;
  logic [IDX_W-1:0] wr_row, wr_col;
  logic             sat_any;
  mac_ctrl_t        issue;
  mac_ctrl_t        s1_ctrl;
  mac_rsp_t         mac_rsp;
  logic signed [63:0] mac_sum;

  // response path
  logic done_valid;
  rsp_t done_data;
  rsp_t skid;
  logic skid_valid;
  logic take;

  // active size: zero acts as one, above the maximum clamps
  always_comb begin
    if (cfg_size == '0) begin
      n = SZ_W'(1);
    end else if (int'(cfg_size) > MAX_SIZE) begin
      n = SZ_W'(MAX_SIZE);
    end else begin
      n = SZ_W'(cfg_size);
    end
    nm1 = IDX_W'(n - SZ_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size <= 7'd64;
    end else if (cfg_we) begin
      cfg_size <= cfg_wdata;
    end
  end

  assign req_ready = (state == ST_IDLE) && !skid_valid;
  assign req_fire  = req_valid && req_ready;
  assign in_range  = (CW'(req.row) < CW'(n)) && (CW'(req.col) < CW'(n));
  // cells outside the last multiply read as zero
  assign hit       = (CW'(req.row) < CW'(last_size)) && (CW'(req.col) < CW'(last_size));
  assign req_addr  = {IDX_W'(req.row), IDX_W'(req.col)};

  // A and B: written by requests, read by the sequencer
  always_ff @(posedge clk) begin
    if (req_fire && in_range && req.operation == OP_WRITE_A) begin
      a_mem[req_addr] <= req.value;
    end
    a_rd <= a_mem[{mi, mh}];
  end

  always_ff @(posedge clk) begin
    if (req_fire && in_range && req.operation == OP_WRITE_B) begin
      b_mem[req_addr] <= req.value;
    end
    b_rd <= b_mem[{mh, mj}];
  end

  // C: written by the mac pipeline cell by cell, read by requests
  always_ff @(posedge clk) begin
    if (mac_rsp.wr) begin
      c_mem[{wr_row, wr_col}] <= mac_sum;
    end
    c_rd <= c_mem[req_addr];
  end

  // one MAC step per cycle while multiplying, h innermost
  always_comb begin
    issue = '0;
    if (state == ST_MUL) begin
      issue.valid = 1'b1;
      issue.first = (mh == '0);
      issue.last  = (mh == nm1);
      issue.done  = (mh == nm1) && (mj == nm1) && (mi == nm1);
    end
  end

  // stage 1 lines up with the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else begin
      s1_ctrl <= issue;
    end
  end

  dmm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (s1_ctrl),
    .a_data (a_rd),
    .b_data (b_rd),
    .rsp    (mac_rsp),
    .sum    (mac_sum)
  );

  // loop counters and C write position
  always_ff @(posedge clk) begin
    if (req_fire && req.operation == OP_MULTIPLY) begin
      mi     <= '0;
      mj     <= '0;
      mh     <= '0;
      wr_row <= '0;
      wr_col <= '0;
    end else begin
      if (state == ST_MUL) begin
        if (mh == nm1) begin
          mh <= '0;
          if (mj == nm1) begin
            mj <= '0;
            mi <= mi + IDX_W'(1);
          end else begin
            mj <= mj + IDX_W'(1);
          end
        end else begin
          mh <= mh + IDX_W'(1);
        end
      end
      if (mac_rsp.wr) begin
        if (wr_col == nm1) begin
          wr_col <= '0;
          wr_row <= wr_row + IDX_W'(1);
        end else begin
          wr_col <= wr_col + IDX_W'(1);
        end
      end
    end
  end

  // response of the request finishing this cycle
  always_comb begin
    done_valid = 1'b0;
    done_data  = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && req.operation != OP_MULTIPLY &&
            !(req.operation == OP_READ_C && in_range)) begin
          done_valid       = 1'b1;
          done_data.status = in_range ? STATUS_OK : STATUS_RANGE;
        end
      end
      ST_READ: begin
        done_valid             = 1'b1;
        done_data.result_value = read_hit ? c_rd : '0;
        done_data.status       = sat_flag ? STATUS_SAT : STATUS_OK;
      end
      ST_MUL, ST_DRAIN: begin
        if (mac_rsp.done) begin
          done_valid       = 1'b1;
          done_data.status = (sat_any || mac_rsp.sat) ? STATUS_SAT : STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_size <= '0;
      sat_flag  <= 1'b0;
      sat_any   <= 1'b0;
      read_hit  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire && req.operation == OP_MULTIPLY) begin
            state   <= ST_MUL;
            sat_any <= 1'b0;
          end else if (req_fire && req.operation == OP_READ_C && in_range) begin
            state    <= ST_READ;
            read_hit <= hit;
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_MUL, ST_DRAIN: begin
          if (issue.done) begin
            state <= ST_DRAIN;
          end
          if (mac_rsp.sat) begin
            sat_any <= 1'b1;
          end
          if (mac_rsp.done) begin
            state     <= ST_IDLE;
            sat_flag  <= sat_any || mac_rsp.sat;
            last_size <= n;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register with one skid entry
  assign take = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!rsp_valid || take) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          rsp_valid <= done_valid;
        end
      end else if (done_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || take) begin
      if (skid_valid) begin
        rsp <= skid;
      end else if (done_valid) begin
        rsp <= done_data;
      end
    end else if (done_valid) begin
      skid <= done_data;
    end
  end

  `include "dense_matrix_multiply_defines.svh"

  `DMM_ASSERT_NEVER(a_skid_overrun, skid_valid && done_valid, "response lost: skid full on completion")
  `DMM_ASSERT_SAME(a_cwrite_in_mul, mac_rsp.wr, state == ST_MUL || state == ST_DRAIN, "C written outside a multiply")
  `DMM_ASSERT_NEXT(a_read_enters, req_fire && req.operation == OP_READ_C && in_range, state == ST_READ, "in-range read did not wait for C data")
  `DMM_ASSERT_NEXT(a_mul_responds, mac_rsp.done, rsp_valid && state == ST_IDLE, "multiply finished without a response")

endmodule

`default_nettype wire

@@ sim/dense_matrix_multiply_checker.sv @@
// response checker for the dense matrix multiply engine: keeps its own copy of
// A, B, C and the size register, predicts every response and compares in order
// depends on dmm_pkg; instantiated beside the block by dense_matrix_multiply_test
module dense_matrix_multiply_checker
  import dmm_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_t       req,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  output int         errors,
  output int         outstanding
);

  localparam int CELLS = MAX_SIZE * MAX_SIZE;

  logic signed [31:0] a_mat [CELLS];
  logic signed [31:0] b_mat [CELLS];
  logic signed [63:0] c_mat [CELLS];
  logic               sat_seen;
  logic [6:0]         size_reg;
  rsp_t               awaited_rsp_q [$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic int active_size();
    if (size_reg == 7'd0) return 1;
    if (size_reg > MAX_SIZE) return MAX_SIZE;
    return int'(size_reg);
  endfunction

  // c = a * b over the active corner, every addition clamped to 64 bits
  function automatic logic form_product();
    int     n, i, j, h;
    logic   sat;
    longint acc, term, sum;
    n = active_size();
    sat = 1'b0;
    foreach (c_mat[k]) c_mat[k] = '0;
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        acc = 0;
        for (h = 0; h < n; h++) begin
          term = longint'(a_mat[i * MAX_SIZE + h]) * longint'(b_mat[h * MAX_SIZE + j]);
          sum = acc + term;
          if (!acc[63] && !term[63] && sum[63]) begin
            sum = ACC_MAX;
            sat = 1'b1;
          end else if (acc[63] && term[63] && !sum[63]) begin
            sum = ACC_MIN;
            sat = 1'b1;
          end
          acc = sum;
        end
        c_mat[i * MAX_SIZE + j] = acc;
      end
    end
    return sat;
  endfunction

  function automatic rsp_t matrix_response(req_t r);
    rsp_t e;
    int   n, idx;
    n = active_size();
    idx = int'(r.row) * MAX_SIZE + int'(r.col);
    e.result_value = '0;
    e.status = STATUS_OK;
    if (r.operation == OP_MULTIPLY) begin
      sat_seen = form_product();
      e.status = sat_seen ? STATUS_SAT : STATUS_OK;
    end else if (r.row >= n || r.col >= n) begin
      e.status = STATUS_RANGE;
    end else begin
      case (r.operation)
        OP_WRITE_A: a_mat[idx] = r.value;
        OP_WRITE_B: b_mat[idx] = r.value;
        OP_READ_C: begin
          e.result_value = c_mat[idx];
          e.status = sat_seen ? STATUS_SAT : STATUS_OK;
        end
        default: ;
      endcase
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      foreach (c_mat[k]) c_mat[k] = '0;
      sat_seen = 1'b0;
      size_reg = 7'd64;
      awaited_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response %h with no request waiting", rsp));
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp.result_value !== want.result_value)
            report_mismatch($sformatf("result_value %h, expected %h",
                                      rsp.result_value, want.result_value));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        end
      end
      if (req_valid && req_ready) awaited_rsp_q.push_back(matrix_response(req));
      if (cfg_we) size_reg = cfg_wdata;
    end
    outstanding = awaited_rsp_q.size();
  end

endmodule

@@ sim/dense_matrix_multiply_test.sv @@
// testbench top for the dense matrix multiply engine: clock, reset, request
// stimulus, size changes and the verdict
// depends on dmm_pkg, dense_matrix_multiply and dense_matrix_multiply_checker
module dense_matrix_multiply_test
  import dmm_pkg::*;
();

  localparam int MAX_SIZE = 64;
  // watchdog limit, with wide margin over the slowest run
  localparam int CYCLE_LIMIT = 400000;
  // largest size whose A and B corners get filled so a multiply may run
  localparam int FILL_MAX = 8;
  localparam int PHASES = 11;
  localparam int RANDOM_PER_PHASE = 24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = 7'd0;

  int errors;
  int outstanding;
  int send_idle_pct = 27;
  int recv_idle_pct = 85;
  int cycles = 0;
  int filled = 0;     // every A and B element inside this corner has been written
  int cur_size = 64;  // size in effect after clamping
  int phase_sizes [PHASES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dense_matrix_multiply #(
    .MAX_SIZE(MAX_SIZE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  dense_matrix_multiply_checker #(
    .MAX_SIZE(MAX_SIZE)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .outstanding(outstanding)
  );

  // response side: ready drops at random, rate set per idling mode
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("dense_matrix_multiply_test failed");
      $finish;
    end
  end

  function automatic req_t make_req(logic [1:0] op, int r, int c, logic [31:0] v);
    req_t q;
    q.operation = op;
    q.row = r[5:0];
    q.col = c[5:0];
    q.value = v;
    return q;
  endfunction

  // q16.16 extremes
  function automatic logic [31:0] extreme_value();
    return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // mix of extremes, values near zero and full random words
  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0, 1: return extreme_value();
      2: return $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
      3, 4, 5: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  // one request: optional random gap, then hold valid until accepted
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  // drain all responses, then write the size register while the block idles
  task automatic set_size(input int v);
    req_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    // every request answers, so the engine is quiet once the queue is empty
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_size = (v == 0) ? 1 : ((v > MAX_SIZE) ? MAX_SIZE : v);
  endtask

  // write the whole n x n corner of A and B so a multiply touches no unwritten element
  task automatic fill_corner(input int n);
    logic extreme;
    int   r, c;
    // all-extreme corners can drive the accumulator into either clamp
    extreme = ($urandom_range(9) < 3);
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++)
        send_request(make_req(OP_WRITE_A, r, c, extreme ? extreme_value() : rand_value()));
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++)
        send_request(make_req(OP_WRITE_B, r, c, extreme ? extreme_value() : rand_value()));
    if (n > filled) filled = n;
  endtask

  // mostly in-range element traffic, a multiply now and then when allowed
  function automatic req_t random_req();
    int         k, hi;
    logic [1:0] op;
    k = $urandom_range(99);
    if (k < 8 && filled >= cur_size) op = OP_MULTIPLY;
    else if (k < 38) op = OP_WRITE_A;
    else if (k < 68) op = OP_WRITE_B;
    else op = OP_READ_C;
    // occasional index anywhere in the field, out of range below full size
    hi = ($urandom_range(9) == 0) ? MAX_SIZE - 1 : cur_size - 1;
    return make_req(op, $urandom_range(hi), $urandom_range(hi), rand_value());
  endfunction

  initial begin
    int p, r, c;
    phase_sizes = '{3, 127, 5, 0, 8, 2, 64, 6, 4, 1, 7};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset size: extreme corners of the index space, C reads zero
    send_request(make_req(OP_WRITE_A, 0, 0, 32'h8000_0000));
    send_request(make_req(OP_WRITE_B, 63, 63, 32'h7fff_ffff));
    send_request(make_req(OP_READ_C, 63, 63, 32'h0000_0000));
    send_request(make_req(OP_READ_C, 0, 63, 32'hffff_ffff));

    // size 2 with every element at the minimum: sums overflow to the positive clamp
    set_size(2);
    for (r = 0; r < 2; r++)
      for (c = 0; c < 2; c++)
        send_request(make_req(OP_WRITE_A, r, c, 32'h8000_0000));
    for (r = 0; r < 2; r++)
      for (c = 0; c < 2; c++)
        send_request(make_req(OP_WRITE_B, r, c, 32'h8000_0000));
    filled = 2;
    // multiply ignores row, col and value
    send_request(make_req(OP_MULTIPLY, 63, 63, 32'hffff_ffff));
    send_request(make_req(OP_READ_C, 1, 1, 32'h0));
    // index at the size: rejected, nothing changes
    send_request(make_req(OP_READ_C, 2, 0, 32'h0));
    send_request(make_req(OP_WRITE_A, 0, 2, 32'h1234_5678));
    send_request(make_req(OP_WRITE_B, 63, 63, 32'h7fff_ffff));

    // size zero acts as one; a clean multiply clears the saturation flag
    set_size(0);
    send_request(make_req(OP_WRITE_A, 0, 0, 32'h0001_0000));
    send_request(make_req(OP_WRITE_B, 0, 0, 32'hffff_0000));
    send_request(make_req(OP_MULTIPLY, 0, 0, 32'h0));
    send_request(make_req(OP_READ_C, 0, 0, 32'h0));
    send_request(make_req(OP_READ_C, 0, 1, 32'h0));

    // size above the maximum acts as the maximum
    set_size(127);
    send_request(make_req(OP_READ_C, 63, 63, 32'h0));
    send_request(make_req(OP_WRITE_A, 63, 0, 32'h0000_ffff));

    // random phases, each at its own size; idling modes change at thirds
    for (p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 85;
        recv_idle_pct <= 27;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      set_size(phase_sizes[p]);
      if (cur_size <= FILL_MAX) begin
        fill_corner(cur_size);
        send_request(make_req(OP_MULTIPLY, $urandom_range(63), $urandom_range(63),
                              rand_value()));
      end
      repeat (RANDOM_PER_PHASE) send_request(random_req());
    end

    // drain, then a short quiet stretch
    req_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("dense_matrix_multiply_test passed");
    end else begin
      $display("dense_matrix_multiply_test failed");
    end
    $finish;
  end

endmodule
